>>> rtl/core/rtm_pkg.sv
package rtm_pkg;

	// Request codes carried in the low bits of the input tuser.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam int KEY_W   = 64;
	localparam int VALUE_W = 64;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_KEY_WIDE  = 2'd1,
		STS_NO_PATH   = 2'd2,
		STS_POOL_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_CHECK,
		S_DECIDE,
		S_ALLOC,
		S_LREAD,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic               mark_pointer;
		logic [VALUE_W-1:0] value;
		logic [KEY_W-1:0]   key;
		logic [1:0]         req_type;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [VALUE_W-1:0] read_value;
	} res_t;

endpackage

>>> rtl/core/radix_table_map.sv
// Channel   Dir  Beat contents (from bit 0 up)
// s_        in   tdata: key[63:0], value[127:64]; tuser: req_type[1:0], mark_pointer[2]
// m_        out  tdata: read_value[63:0]; tuser: status[1:0]
//
// After reset the whole node store, NODE_COUNT * 2^INDEX_BITS entries (8192 by
// default), is swept to zero, one entry per cycle; s_tready stays low meanwhile.
// One request is processed at a time, at a pace set by the single memory port:
// each level's read depends on the entry read above it, and each new node costs
// one write.
// A finished result waits in the output register, so a new beat is accepted while
// m_tready is low; the sequencer only stalls if a second result is ready before
// the first is taken.
module radix_table_map #(
	parameter int LEVELS     = 6,
	parameter int INDEX_BITS = 8,
	parameter int NODE_COUNT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // key[63:0], value[127:64]
	input  logic [2:0]   s_tuser,   // req_type[1:0], mark_pointer[2]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // read_value[63:0]
	output logic [1:0]   m_tuser    // status[1:0]
);

	// The store holds one 2^INDEX_BITS-entry table per node, addressed as
	// {node, slot}.
	localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int ADDR_W = NODE_W + INDEX_BITS;
	localparam int DEPTH  = NODE_COUNT << INDEX_BITS;

	rtm_pkg::req_t               req;
	rtm_pkg::res_t               res;
	logic                        res_valid;
	logic                        res_ready;
	logic [ADDR_W-1:0]           mem_addr;
	logic                        mem_we;
	logic [rtm_pkg::VALUE_W-1:0] mem_wdata;
	logic [rtm_pkg::VALUE_W-1:0] mem_rdata;
	logic                        out_valid_q;
	rtm_pkg::res_t               out_q;

	// Unpack the input beat.
	assign req.req_type     = s_tuser[1:0];
	assign req.mark_pointer = s_tuser[2];
	assign req.key          = s_tdata[63:0];
	assign req.value        = s_tdata[127:64];

	rtm_ctrl #(
		.LEVELS     (LEVELS),
		.INDEX_BITS (INDEX_BITS),
		.NODE_COUNT (NODE_COUNT),
		.NODE_W     (NODE_W),
		.ADDR_W     (ADDR_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_req    (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_addr  (mem_addr),
		.mem_we    (mem_we),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	rtm_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.addr  (mem_addr),
		.we    (mem_we),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Output register: takes a new result whenever it is empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q.read_value;
	assign m_tuser  = out_q.status;

endmodule

>>> rtl/core/rtm_store.sv
// Single-port node table memory with a registered read.
module rtm_store #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic                         clk,
	input  logic [ADDR_W-1:0]            addr,
	input  logic                         we,
	input  logic [rtm_pkg::VALUE_W-1:0]  wdata,
	output logic [rtm_pkg::VALUE_W-1:0]  rdata
);

	logic [rtm_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/core/rtm_ctrl.sv
// Walk sequencer: clears the store after reset, descends the levels one
// dependent read at a time, allocates nodes and performs the leaf access.
module rtm_ctrl #(
	parameter int LEVELS     = 6,
	parameter int INDEX_BITS = 8,
	parameter int NODE_COUNT = 32,
	parameter int NODE_W     = 5,
	parameter int ADDR_W     = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rtm_pkg::req_t                in_req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output rtm_pkg::res_t                res,
	output logic [ADDR_W-1:0]            mem_addr,
	output logic                         mem_we,
	output logic [rtm_pkg::VALUE_W-1:0]  mem_wdata,
	input  logic [rtm_pkg::VALUE_W-1:0]  mem_rdata
);

	localparam int DEPTH    = NODE_COUNT << INDEX_BITS;
	localparam int LEAF     = LEVELS - 1;
	localparam int KEY_BITS = LEVELS * INDEX_BITS;
	localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int FREE_W   = $clog2(NODE_COUNT + 1);
	localparam int CNT_W    = FREE_W + LVL_W + 1;

	rtm_pkg::fsm_t              state_q, state_d;
	logic [LVL_W-1:0]           level_q, level_d;
	logic [NODE_W-1:0]          node_q, node_d;
	logic [FREE_W-1:0]          next_free_q, free_d;
	logic [ADDR_W-1:0]          clr_q, clr_d;
	logic [1:0]                 req_q;
	rtm_pkg::status_t           res_status_q, sts_d;
	logic [rtm_pkg::VALUE_W-1:0] res_value_q, rval_d;
	logic [rtm_pkg::KEY_W-1:0]  key_q;
	logic [rtm_pkg::VALUE_W-1:0] value_q;

	logic [INDEX_BITS-1:0]      slot [LEVELS];
	logic [LVL_W-1:0]           lvl_nx;
	logic                       key_wide;
	logic                       child_ok;
	logic                       at_leaf;
	logic                       more;
	logic                       pool_short;

	// Slot of each level: the top key bits index the root.
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			if ((LEVELS - 1 - l) * INDEX_BITS >= 64) begin
				slot[l] = '0;
			end else begin
				slot[l] = INDEX_BITS'(key_q >> ((LEVELS - 1 - l) * INDEX_BITS));
			end
		end
	end

	assign key_wide   = (KEY_BITS >= 64) ? 1'b0 : ((in_req.key >> KEY_BITS) != '0);
	assign child_ok   = (mem_rdata != '0) && (mem_rdata < 64'(NODE_COUNT));
	assign lvl_nx     = level_q + 1'b1;
	assign at_leaf    = (int'(level_q) == LEAF);
	assign more       = (int'(level_q) + 1 < LEAF);
	assign pool_short = (CNT_W'(next_free_q) + CNT_W'(LVL_W'(LEAF) - level_q))
		> CNT_W'(NODE_COUNT);

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		node_d    = node_q;
		free_d    = next_free_q;
		clr_d     = clr_q;
		sts_d     = res_status_q;
		rval_d    = res_value_q;
		mem_we    = 1'b0;
		mem_addr  = {node_q, slot[level_q]};
		mem_wdata = '0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			rtm_pkg::S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
				if (clr_q == ADDR_W'(DEPTH - 1)) begin
					state_d = rtm_pkg::S_IDLE;
				end else begin
					clr_d = clr_q + 1'b1;
				end
			end
			rtm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				level_d  = '0;
				node_d   = '0;
				rval_d   = '0;
				sts_d    = rtm_pkg::STS_OK;
				if (in_valid) begin
					if (in_req.req_type == rtm_pkg::REQ_NOP) begin
						state_d = rtm_pkg::S_DONE;
					end else if (key_wide) begin
						sts_d   = rtm_pkg::STS_KEY_WIDE;
						state_d = rtm_pkg::S_DONE;
					end else if (LEAF == 0) begin
						state_d = rtm_pkg::S_DECIDE;
					end else begin
						state_d = rtm_pkg::S_WALK;
					end
				end
			end
			rtm_pkg::S_WALK: begin
				// Root entry read issued through the default address.
				state_d = rtm_pkg::S_CHECK;
			end
			rtm_pkg::S_CHECK: begin
				if (child_ok) begin
					node_d  = mem_rdata[NODE_W-1:0];
					level_d = lvl_nx;
					if (more) begin
						// Chain straight into the next level's read.
						mem_addr = {mem_rdata[NODE_W-1:0], slot[lvl_nx]};
					end else begin
						state_d = rtm_pkg::S_DECIDE;
					end
				end else begin
					state_d = rtm_pkg::S_DECIDE;
				end
			end
			rtm_pkg::S_DECIDE: begin
				unique case (req_q)
					rtm_pkg::REQ_INSERT: begin
						if (pool_short) begin
							sts_d   = rtm_pkg::STS_POOL_FULL;
							state_d = rtm_pkg::S_DONE;
						end else if (at_leaf) begin
							mem_we    = 1'b1;
							mem_wdata = value_q;
							state_d   = rtm_pkg::S_DONE;
						end else begin
							state_d = rtm_pkg::S_ALLOC;
						end
					end
					rtm_pkg::REQ_LOOKUP: begin
						if (!at_leaf) begin
							sts_d   = rtm_pkg::STS_NO_PATH;
							state_d = rtm_pkg::S_DONE;
						end else begin
							state_d = rtm_pkg::S_LREAD;
						end
					end
					rtm_pkg::REQ_DELETE: begin
						if (!at_leaf) begin
							sts_d   = rtm_pkg::STS_NO_PATH;
							state_d = rtm_pkg::S_DONE;
						end else begin
							mem_we  = 1'b1;
							state_d = rtm_pkg::S_DONE;
						end
					end
					default: begin
						state_d = rtm_pkg::S_DONE;
					end
				endcase
			end
			rtm_pkg::S_ALLOC: begin
				// Link a fresh node; it reads as zero since the store was cleared.
				mem_we    = 1'b1;
				mem_wdata = 64'(next_free_q);
				node_d    = NODE_W'(next_free_q);
				free_d    = next_free_q + 1'b1;
				level_d   = lvl_nx;
				state_d   = rtm_pkg::S_DECIDE;
			end
			rtm_pkg::S_LREAD: begin
				rval_d  = mem_rdata;
				state_d = rtm_pkg::S_DONE;
			end
			rtm_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = rtm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rtm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rtm_pkg::S_CLEAR;
			level_q      <= '0;
			node_q       <= '0;
			next_free_q  <= FREE_W'(1);
			clr_q        <= '0;
			req_q        <= rtm_pkg::REQ_NOP;
			res_status_q <= rtm_pkg::STS_OK;
		end else begin
			state_q      <= state_d;
			level_q      <= level_d;
			node_q       <= node_d;
			next_free_q  <= free_d;
			clr_q        <= clr_d;
			res_status_q <= sts_d;
			if (in_ready && in_valid) begin
				req_q <= in_req.req_type;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_value_q <= rval_d;
		if (in_ready && in_valid) begin
			key_q   <= in_req.key;
			value_q <= in_req.value | {in_req.mark_pointer, 63'b0};
		end
	end

	assign res.status     = res_status_q;
	assign res.read_value = res_value_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q <= FREE_W'(NODE_COUNT))
		else $error("node allocator ran past the pool");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtm_pkg::S_ALLOC |-> next_free_q < FREE_W'(NODE_COUNT))
		else $error("allocation started without a free node");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != rtm_pkg::S_ALLOC |=> $stable(next_free_q))
		else $error("allocator moved outside an allocation step");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mem_we)
		else $error("store written while waiting for a request");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rtm_pkg::S_CHECK |-> int'(level_q) < LEAF)
		else $error("walk read past the leaf level");

endmodule

>>> verif/tb_radix_table_map.sv
// Testbench for radix_table_map.
//
// Requests go in on the slave stream and status/read-value beats come back
// on the master stream, strictly in order. Every accepted request is run
// through a shadow copy of the node pool kept in this file (map_predict).
// The beat that the shadow map produces, or a hand-typed beat for the
// obvious rows of the directed table, is queued, and every result beat is
// compared with the oldest queued entry.
//
// The directed table walks the error codes, the key extremes, marked and
// zero values, delete, the no-op request, and fills the node pool up to its
// last node so that pool exhaustion and the one-node-left boundary are hit.
// The random part then mostly reuses key prefixes whose paths exist, so
// that lookups, deletes and overwrites reach the leaf level, with a share
// of branched, fully random and over-wide keys mixed in.
module tb_radix_table_map;

	timeunit 1ns;
	timeprecision 1ps;

	import rtm_pkg::*;

	// Default geometry of the block under test.
	localparam int LEVELS     = 6;
	localparam int INDEX_BITS = 8;
	localparam int NODE_COUNT = 32;
	localparam int FANOUT     = 1 << INDEX_BITS;
	localparam int KEY_BITS   = LEVELS * INDEX_BITS;
	localparam logic [63:0] MARK_BIT = 64'h8000_0000_0000_0000;

	// Run length: total request beats, and how many at the end go without
	// any idling on either side.
	localparam int TOTAL_BEATS = 950;
	localparam int CALM_BEATS  = 100;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;   // key[63:0], value[127:64]
	logic [2:0]   s_tuser = '0;   // req_type[1:0], mark_pointer[2]
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;        // read_value[63:0]
	logic [1:0]   m_tuser;        // status[1:0]

	always #6 clk = ~clk;

	radix_table_map #(
		.LEVELS(LEVELS),
		.INDEX_BITS(INDEX_BITS),
		.NODE_COUNT(NODE_COUNT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	// One row of the directed table. When has_known is set the result is
	// typed in by hand; otherwise the shadow map supplies it.
	typedef struct {
		req_t beat;
		bit   has_known;
		res_t known;
	} stim_row_t;

	// Shadow of the node pool and of the bump allocator.
	logic [63:0] shadow_nodes [NODE_COUNT * FANOUT];
	int unsigned shadow_next;

	res_t        replies_due [$];     // results still owed by the block, oldest first
	logic [39:0] live_prefixes [$];   // key bits 47:8 of paths known to exist
	stim_row_t   directed_rows [$];
	res_t        want;
	int          mismatch_count = 0;
	bit          calm = 1'b0;         // set for the last stretch: no idling at all

	// Slot index that a key selects at a given level; level 0 is the root
	// and takes the top group of key bits.
	function automatic int unsigned slot_at(input logic [63:0] key, input int level);
		int shift;
		shift = (LEVELS - 1 - level) * INDEX_BITS;
		if (shift >= 64)
			return 0;
		return int'((key >> shift) & 64'(FANOUT - 1));
	endfunction

	// Follows existing children from the root. Returns how many levels were
	// descended and leaves the deepest node reached in node. A child index of
	// zero, or one outside the pool, ends the walk.
	function automatic int follow_path(input logic [63:0] key, output int unsigned node);
		int unsigned cur;
		int          level;
		bit          stop;
		logic [63:0] child;
		cur = 0;
		level = 0;
		stop = 1'b0;
		while (!stop && level < LEVELS - 1) begin
			child = shadow_nodes[cur * FANOUT + slot_at(key, level)];
			if (child == 0 || child >= NODE_COUNT) begin
				stop = 1'b1;
			end else begin
				cur = child[31:0];
				level++;
			end
		end
		node = cur;
		return level;
	endfunction

	// Applies one request to the shadow map and returns the result beat the
	// block must produce for it.
	function automatic res_t map_predict(input req_t r);
		res_t        o;
		int          reached;
		int          level;
		int unsigned node;
		int unsigned need;
		int unsigned fresh;
		logic [63:0] stored;
		o.status = STS_OK;
		o.read_value = '0;
		if (r.req_type != REQ_NOP && (r.key >> KEY_BITS) != 0) begin
			o.status = STS_KEY_WIDE;
		end else if (r.req_type == REQ_INSERT) begin
			reached = follow_path(r.key, node);
			need = LEVELS - 1 - reached;
			// All-or-nothing: an insert that cannot get every missing level
			// allocates nothing at all.
			if (shadow_next > NODE_COUNT || need > NODE_COUNT - shadow_next) begin
				o.status = STS_POOL_FULL;
			end else begin
				for (level = reached; level < LEVELS - 1; level++) begin
					fresh = shadow_next;
					shadow_next++;
					shadow_nodes[node * FANOUT + slot_at(r.key, level)] = 64'(fresh);
					node = fresh;
				end
				stored = r.value;
				if (r.mark_pointer)
					stored = stored | MARK_BIT;
				shadow_nodes[node * FANOUT + slot_at(r.key, LEVELS - 1)] = stored;
			end
		end else if (r.req_type == REQ_LOOKUP || r.req_type == REQ_DELETE) begin
			reached = follow_path(r.key, node);
			if (reached != LEVELS - 1) begin
				o.status = STS_NO_PATH;
			end else if (r.req_type == REQ_LOOKUP) begin
				o.read_value = shadow_nodes[node * FANOUT + slot_at(r.key, LEVELS - 1)];
			end else begin
				shadow_nodes[node * FANOUT + slot_at(r.key, LEVELS - 1)] = '0;
			end
		end
		return o;
	endfunction

	task automatic add_row(input logic [1:0] req, input logic [63:0] key,
			input logic [63:0] value, input logic mark, input bit has_known,
			input status_t st, input logic [63:0] rv);
		stim_row_t row;
		row.beat.req_type = req;
		row.beat.key = key;
		row.beat.value = value;
		row.beat.mark_pointer = mark;
		row.has_known = has_known;
		row.known.status = st;
		row.known.read_value = rv;
		directed_rows.push_back(row);
	endtask

	// Presents one request beat and holds it until the block takes it. The
	// shadow map is updated at the accepting edge, so its order matches the
	// order in which the block serves requests. Afterwards the sender may go
	// quiet for a burst; otherwise valid simply stays high for the next beat.
	task automatic send_request(input req_t r, input bit has_known, input res_t known);
		res_t model;
		s_tdata <= {r.value, r.key};
		s_tuser <= {r.mark_pointer, r.req_type};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model = map_predict(r);
		replies_due.push_back(has_known ? known : model);
		if (r.req_type == REQ_INSERT && model.status == STS_OK)
			live_prefixes.push_back(r.key[47:8]);
		if (!calm && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// Random key. Most keys reuse a prefix whose path exists, with the leaf
	// slot often drawn from a narrow range so that inserts, lookups and deletes
	// meet each other. Some of those get one inner byte changed to branch
	// off an existing path; the rest are fully random or too wide.
	function automatic logic [63:0] draw_key();
		int          sel;
		int          lvl;
		logic [63:0] k;
		sel = $urandom_range(99);
		k = '0;
		if (sel < 78) begin
			k[47:8] = live_prefixes[$urandom_range(live_prefixes.size() - 1)];
			k[7:0] = ($urandom_range(1) == 1) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
			if (sel >= 70) begin
				lvl = $urandom_range(1, 5);
				k[lvl * 8 +: 8] = 8'($urandom_range(255));
			end
		end else if (sel < 92) begin
			k[47:0] = {16'($urandom), 32'($urandom)};
		end else begin
			k[47:0] = {16'($urandom), 32'($urandom)};
			k[63:48] = 16'($urandom_range(1, 65535));
		end
		return k;
	endfunction

	// Stimulus: reset, the directed table, then random requests.
	initial begin
		req_t r;
		res_t none;
		int   sel;
		none.status = STS_OK;
		none.read_value = '0;
		shadow_next = 1;
		for (int i = 0; i < NODE_COUNT * FANOUT; i++)
			shadow_nodes[i] = '0;

		// Nothing exists yet: every walk stops at the root.
		add_row(REQ_LOOKUP, 64'h0, 64'h0, 1'b0, 1'b1, STS_NO_PATH, 64'h0);
		add_row(REQ_DELETE, 64'h0000_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1, STS_NO_PATH, 64'h0);
		// Keys with bits above the 48-bit range are refused for every
		// request type except the no-op.
		add_row(REQ_INSERT, 64'h0001_0000_0000_0000, 64'h5A5A, 1'b1, 1'b1, STS_KEY_WIDE, 64'h0);
		add_row(REQ_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b1, STS_KEY_WIDE, 64'h0);
		add_row(REQ_DELETE, 64'h8000_0000_0000_0000, 64'h0, 1'b0, 1'b1, STS_KEY_WIDE, 64'h0);
		add_row(REQ_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1,
			STS_OK, 64'h0);
		// Lowest and highest keys, each building a full path of five nodes.
		add_row(REQ_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, STS_OK, 64'h0);
		add_row(REQ_LOOKUP, 64'h0, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_INSERT, 64'h0000_FFFF_FFFF_FFFF, 64'h1234, 1'b1, 1'b1, STS_OK, 64'h0);
		add_row(REQ_LOOKUP, 64'h0000_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		// Empty leaf entry in a leaf node that exists.
		add_row(REQ_LOOKUP, 64'h0000_FFFF_FFFF_FF00, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		// A stored zero reads back like an absent entry.
		add_row(REQ_INSERT, 64'h1, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_LOOKUP, 64'h1, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_DELETE, 64'h0, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_LOOKUP, 64'h0, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		// The walk gets down to the last inner level and finds no leaf node.
		add_row(REQ_LOOKUP, 64'h100, 64'h0, 1'b0, 1'b0, STS_OK, 64'h0);
		// Four new root branches take 20 more nodes, leaving exactly one.
		add_row(REQ_INSERT, 64'h0000_0100_0000_0000, 64'h11, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_INSERT, 64'h0000_0200_0000_0000, 64'h22, 1'b1, 1'b0, STS_OK, 64'h0);
		add_row(REQ_INSERT, 64'h0000_0300_0000_0000, 64'h33, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_INSERT, 64'h0000_0400_0000_0000, 64'h44, 1'b1, 1'b0, STS_OK, 64'h0);
		// Five nodes needed with one left: refused, nothing allocated.
		add_row(REQ_INSERT, 64'h0000_0500_0000_0000, 64'h55, 1'b0, 1'b1, STS_POOL_FULL, 64'h0);
		// One node needed with one left: taken, and the pool is now empty.
		add_row(REQ_INSERT, 64'h0000_0100_0000_0100, 64'h66, 1'b0, 1'b0, STS_OK, 64'h0);
		add_row(REQ_INSERT, 64'h0000_0100_0000_0200, 64'h77, 1'b0, 1'b1, STS_POOL_FULL, 64'h0);
		add_row(REQ_LOOKUP, 64'h0000_0100_0000_0200, 64'h0, 1'b0, 1'b1, STS_NO_PATH, 64'h0);
		// Inserts along existing paths still work with the pool empty.
		add_row(REQ_INSERT, 64'h0000_0200_0000_007F, 64'hDEAD_BEEF_0BAD_F00D, 1'b1, 1'b0,
			STS_OK, 64'h0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_request(directed_rows[i].beat, directed_rows[i].has_known,
				directed_rows[i].known);

		for (int n = directed_rows.size(); n < TOTAL_BEATS; n++) begin
			if (n >= TOTAL_BEATS - CALM_BEATS)
				calm = 1'b1;
			sel = $urandom_range(99);
			if (sel < 40)
				r.req_type = REQ_INSERT;
			else if (sel < 72)
				r.req_type = REQ_LOOKUP;
			else if (sel < 94)
				r.req_type = REQ_DELETE;
			else
				r.req_type = REQ_NOP;
			r.key = draw_key();
			sel = $urandom_range(9);
			if (sel == 0)
				r.value = '0;
			else if (sel == 1)
				r.value = '1;
			else
				r.value = {$urandom, $urandom};
			r.mark_pointer = 1'($urandom_range(1));
			send_request(r, 1'b0, none);
		end
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any result it still owes
		// or should not produce.
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Result side: m_tready drops for bursts of random length at random points,
	// and stays high once the final stretch begins.
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker: values are sampled as they stood at the clock edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (replies_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: result beat with none owed: status %0d value %h",
					$time, m_tuser, m_tdata);
			end else begin
				want = replies_due.pop_front();
				if (m_tuser !== want.status) begin
					mismatch_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_tuser);
				end
				if (m_tdata !== want.read_value) begin
					mismatch_count++;
					$display("%0t: read_value expected %h actual %h",
						$time, want.read_value, m_tdata);
				end
			end
		end
	end

	// Watchdog: the slowest correct run, with the clearing sweep after reset,
	// needs well under a tenth of this.
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/core/rtm_pkg.sv
rtl/core/rtm_store.sv
rtl/core/rtm_ctrl.sv
rtl/core/radix_table_map.sv
verif/tb_radix_table_map.sv
